/* rtl/fprc_pkg.sv */
// Package for the framed packet receiver: phase and result-kind codes,
// register indexes, the bytewise CRC-16 step and the command lookup.
// No dependencies.
`default_nettype none

package fprc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CrcW      = 16;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned OutDataW  = 32;

  localparam logic [CrcW-1:0]  CrcPoly      = 16'h1021;
  localparam logic [ByteW-1:0] SyncFirstRst = 8'h6A;
  localparam logic [ByteW-1:0] SyncSecRst   = 8'h01;
  localparam logic [ByteW-1:0] MaxLenRst    = 8'hFF;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_SYNC2 = 8'b0000_0010,
    PH_LENHI = 8'b0000_0100,
    PH_LENLO = 8'b0000_1000,
    PH_CMD   = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_CRCHI = 8'b0100_0000,
    PH_CRCLO = 8'b1000_0000
  } phase_e;

  // Result kinds carried on tuser.
  typedef enum logic [KindW-1:0] {
    KIND_CMD     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_GOOD    = 2'd2,
    KIND_CRC_ERR = 2'd3
  } kind_e;

  // Register indexes (byte address = 4 * index).
  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAX_LEN     = 2'd2
  } reg_idx_e;

  // Known command codes.
  localparam logic [ByteW-1:0] CmdA = 8'h01;
  localparam logic [ByteW-1:0] CmdB = 8'h31;
  localparam logic [ByteW-1:0] CmdC = 8'h32;
  localparam logic [ByteW-1:0] CmdD = 8'h70;
  localparam logic [ByteW-1:0] CmdE = 8'hF1;
  localparam logic [ByteW-1:0] CmdF = 8'hF0;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0]  crc_in,
                                               input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < ByteW; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic is_known_cmd(input logic [ByteW-1:0] c);
    return (c == CmdA) || (c == CmdB) || (c == CmdC) ||
           (c == CmdD) || (c == CmdE) || (c == CmdF);
  endfunction

endpackage

`default_nettype wire

/* rtl/framed_packet_receiver_crc16.sv */
// Framed packet receiver with CRC-16 check, top level.
// Depends on fprc_pkg.
`default_nettype none

// Hunts a byte stream for frames: sync_first, sync_second, 16-bit big-endian
// payload length, command byte, payload, big-endian CRC-16 (poly 0x1021,
// init 0, no reflection) over sync through last payload byte. One result is
// sent for the command byte, one per payload byte, and a good / CRC-error
// verdict after the second CRC byte; every result of a frame carries a flag
// for the six known commands. A length above max_payload_len (or 256 and up)
// or a wrong second sync byte drops back to hunt; a mismatching second sync
// byte is not retried as a first sync. tlast on the input (end of chunk)
// returns the parser to hunt after its byte is handled.
// Rate: one byte per clock. Each accepted byte updates the parser state and
// CRC in the cycle it is taken (bytewise parallel CRC), and any result it
// causes lands in the output register the next cycle. The input is ready
// whenever that output register is empty or being drained, so a stall on the
// output side costs exactly the stalled cycles. No clearing pass after reset.
// Config writes are for the user to make only while the block is idle; the block does not enforce it.
module framed_packet_receiver_crc16 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fprc_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [fprc_pkg::CfgDataW-1:0] pwdata,
  output      logic [fprc_pkg::CfgDataW-1:0] prdata,
  output      logic                          pready,
  // Input byte stream
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  input  wire logic [fprc_pkg::ByteW-1:0]    s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic                          s_axis_tlast_i,   // end_of_chunk
  // Result stream
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [7:0] out_byte, [15:8] byte_index, [23:16] frame_len, [24] known_command,
  // [31:25] zero
  output      logic [fprc_pkg::OutDataW-1:0] m_axis_tdata_o,
  output      logic [fprc_pkg::KindW-1:0]    m_axis_tuser_o    // [1:0] out_kind
);

  localparam int unsigned BW = fprc_pkg::ByteW;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [BW-1:0] sync_first_q, sync_second_q, max_len_q;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= fprc_pkg::SyncFirstRst;
      sync_second_q <= fprc_pkg::SyncSecRst;
      max_len_q     <= fprc_pkg::MaxLenRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fprc_pkg::REG_SYNC_FIRST:  sync_first_q  <= pwdata[BW-1:0];
        fprc_pkg::REG_SYNC_SECOND: sync_second_q <= pwdata[BW-1:0];
        fprc_pkg::REG_MAX_LEN:     max_len_q     <= pwdata[BW-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fprc_pkg::REG_SYNC_FIRST:  prdata = {24'd0, sync_first_q};
      fprc_pkg::REG_SYNC_SECOND: prdata = {24'd0, sync_second_q};
      fprc_pkg::REG_MAX_LEN:     prdata = {24'd0, max_len_q};
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: take a request whenever the output register can move on
  // ---------------------------------------------------------------------
  logic out_valid_q, out_valid_d;
  logic in_acc;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------
  fprc_pkg::phase_e        phase_q, phase_d;
  logic [BW-1:0]           len_hi_q, len_hi_d;    // length high byte
  logic [BW-1:0]           len_q, len_d;          // accepted payload length
  logic [BW-1:0]           cnt_q, cnt_d;          // payload bytes seen
  logic [fprc_pkg::CrcW-1:0] crc_q, crc_d;
  logic [BW-1:0]           rx_crc_hi_q, rx_crc_hi_d;
  logic                    known_q, known_d;

  logic [BW-1:0]           b;
  logic [fprc_pkg::CrcW-1:0] crc_upd;
  logic [BW:0]             cnt_inc;

  // Result being formed for this request
  logic                    emit;
  fprc_pkg::kind_e         res_kind;
  logic [BW-1:0]           res_byte, res_idx;

  assign b       = s_axis_tdata_i;
  assign crc_upd = fprc_pkg::crc_step(
                     (phase_q == fprc_pkg::PH_HUNT) ? '0 : crc_q, b);
  assign cnt_inc = {1'b0, cnt_q} + {{BW{1'b0}}, 1'b1};

  always_comb begin
    phase_d     = phase_q;
    len_hi_d    = len_hi_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    rx_crc_hi_d = rx_crc_hi_q;
    known_d     = known_q;
    emit        = 1'b0;
    res_kind    = fprc_pkg::KIND_CMD;
    res_byte    = '0;
    res_idx     = '0;

    case (phase_q)
      fprc_pkg::PH_HUNT: begin
        if (b == sync_first_q) begin
          crc_d   = crc_upd;
          phase_d = fprc_pkg::PH_SYNC2;
        end
      end
      fprc_pkg::PH_SYNC2: begin
        if (b == sync_second_q) begin
          crc_d   = crc_upd;
          phase_d = fprc_pkg::PH_LENHI;
        end else begin
          phase_d = fprc_pkg::PH_HUNT;
        end
      end
      fprc_pkg::PH_LENHI: begin
        len_hi_d = b;
        crc_d    = crc_upd;
        phase_d  = fprc_pkg::PH_LENLO;
      end
      fprc_pkg::PH_LENLO: begin
        // Length must be below 256 and within the configured limit.
        if (len_hi_q == '0 && b <= max_len_q) begin
          len_d   = b;
          crc_d   = crc_upd;
          phase_d = fprc_pkg::PH_CMD;
        end else begin
          phase_d = fprc_pkg::PH_HUNT;
        end
      end
      fprc_pkg::PH_CMD: begin
        crc_d    = crc_upd;
        known_d  = fprc_pkg::is_known_cmd(b);
        cnt_d    = '0;
        emit     = 1'b1;
        res_kind = fprc_pkg::KIND_CMD;
        res_byte = b;
        phase_d  = (len_q == '0) ? fprc_pkg::PH_CRCHI : fprc_pkg::PH_DATA;
      end
      fprc_pkg::PH_DATA: begin
        crc_d    = crc_upd;
        emit     = 1'b1;
        res_kind = fprc_pkg::KIND_PAYLOAD;
        res_byte = b;
        res_idx  = cnt_q;
        cnt_d    = cnt_inc[BW-1:0];
        if (cnt_inc >= {1'b0, len_q}) begin
          phase_d = fprc_pkg::PH_CRCHI;
        end
      end
      fprc_pkg::PH_CRCHI: begin
        rx_crc_hi_d = b;
        phase_d     = fprc_pkg::PH_CRCLO;
      end
      fprc_pkg::PH_CRCLO: begin
        emit     = 1'b1;
        res_kind = ({rx_crc_hi_q, b} == crc_q) ? fprc_pkg::KIND_GOOD
                                               : fprc_pkg::KIND_CRC_ERR;
        phase_d  = fprc_pkg::PH_HUNT;
      end
      default: begin
        phase_d = fprc_pkg::PH_HUNT;
      end
    endcase

    // End of chunk: byte handled as usual, then back to hunt.
    if (s_axis_tlast_i) begin
      phase_d = fprc_pkg::PH_HUNT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fprc_pkg::PH_HUNT;
      known_q     <= 1'b0;
      len_hi_q    <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      crc_q       <= '0;
      rx_crc_hi_q <= '0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      known_q     <= known_d;
      len_hi_q    <= len_hi_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      crc_q       <= crc_d;
      rx_crc_hi_q <= rx_crc_hi_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [fprc_pkg::OutDataW-1:0] out_data_q;
  fprc_pkg::kind_e               out_kind_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s_axis_tready_o) begin
      out_valid_d = in_acc && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      out_kind_q <= res_kind;
      out_data_q <= {7'd0, known_d, len_d, res_idx, res_byte};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

endmodule

`default_nettype wire

/* tb/tb_framed_packet_receiver_crc16.sv */
// Self-checking testbench for framed_packet_receiver_crc16: directed and random
// byte streams against a built-in frame parser model, checked result by result.
// Depends on fprc_pkg and the framed_packet_receiver_crc16 RTL.
`default_nettype none

module tb_framed_packet_receiver_crc16;

  localparam int unsigned MaxFramePayload = 256;
  localparam int unsigned CycleLimit      = 400000;
  localparam int unsigned DrainCycles     = 4;
  localparam logic [1:0]  RegUnused       = 2'd3;  // no register behind this index

  // One byte on the input stream and one expected result on the output stream.
  typedef struct {
    logic [7:0] b;
    logic       eoc;
  } rx_byte_t;

  typedef struct packed {
    fprc_pkg::kind_e kind;
    logic [7:0]      data;
    logic [7:0]      idx;
    logic [7:0]      flen;
    logic            known;
  } frame_result_t;

  // Clock, reset, ports.
  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] in_byte
  logic        s_tlast  = 1'b0; // end_of_chunk
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [7:0] byte, [15:8] index, [23:16] length, [24] known
  logic [1:0]  m_tuser;         // [1:0] out_kind

  always #10 clk_i = ~clk_i;

  framed_packet_receiver_crc16 i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // Parser model state and register shadow copies
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_sync1  = fprc_pkg::SyncFirstRst;
  logic [7:0]  cfg_sync2  = fprc_pkg::SyncSecRst;
  logic [7:0]  cfg_maxlen = fprc_pkg::MaxLenRst;

  fprc_pkg::phase_e rx_phase = fprc_pkg::PH_HUNT;
  logic [8:0]  pay_cnt    = '0;
  logic [15:0] pay_len    = '0;
  logic [15:0] crc_acc    = '0;
  logic [15:0] crc_rx     = '0;
  logic        cmd_known  = 1'b0;

  rx_byte_t      byte_q[$];    // requests waiting to be sent
  frame_result_t result_q[$];  // results the block still owes us
  rx_byte_t      nxt;
  frame_result_t got, want;

  int unsigned gap_left, stall_left, cycle_cnt;
  int unsigned mismatch_cnt, pushed_cnt, setting_cnt;
  int unsigned n_cmd, n_pay, n_good, n_bad;
  logic        no_idle = 1'b0;   // stretches with both sides streaming flat out

  logic [7:0] known_cmds [6] = '{fprc_pkg::CmdA, fprc_pkg::CmdB, fprc_pkg::CmdC,
                                 fprc_pkg::CmdD, fprc_pkg::CmdE, fprc_pkg::CmdF};

  // CRC-16, poly 0x1021, MSB first, one byte at a time.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ fprc_pkg::CrcPoly) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic cmd_is_known(input logic [7:0] c);
    return (c == fprc_pkg::CmdA) || (c == fprc_pkg::CmdB) || (c == fprc_pkg::CmdC) ||
           (c == fprc_pkg::CmdD) || (c == fprc_pkg::CmdE) || (c == fprc_pkg::CmdF);
  endfunction

  function automatic void queue_result(input fprc_pkg::kind_e k, input logic [7:0] d,
                                       input logic [7:0] i);
    frame_result_t r;
    r.kind  = k;
    r.data  = d;
    r.idx   = i;
    r.flen  = pay_len[7:0];
    r.known = cmd_known;
    result_q.push_back(r);
  endfunction

  // Advance the frame parser by one accepted byte; queue the result it causes.
  function automatic void parse_byte(input logic [7:0] b, input logic eoc);
    case (rx_phase)
      fprc_pkg::PH_HUNT: begin
        if (b == cfg_sync1) begin
          crc_acc  = crc16_byte(16'h0000, b);
          rx_phase = fprc_pkg::PH_SYNC2;
        end
      end
      fprc_pkg::PH_SYNC2: begin
        // a mismatch is dropped, not retried as a first sync byte
        if (b == cfg_sync2) begin
          crc_acc  = crc16_byte(crc_acc, b);
          rx_phase = fprc_pkg::PH_LENHI;
        end else begin
          rx_phase = fprc_pkg::PH_HUNT;
        end
      end
      fprc_pkg::PH_LENHI: begin
        pay_len  = {b, 8'h00};
        crc_acc  = crc16_byte(crc_acc, b);
        rx_phase = fprc_pkg::PH_LENLO;
      end
      fprc_pkg::PH_LENLO: begin
        pay_len = pay_len | {8'h00, b};
        if (pay_len < MaxFramePayload && pay_len <= {8'h00, cfg_maxlen}) begin
          crc_acc  = crc16_byte(crc_acc, b);
          rx_phase = fprc_pkg::PH_CMD;
        end else begin
          rx_phase = fprc_pkg::PH_HUNT;
        end
      end
      fprc_pkg::PH_CMD: begin
        crc_acc   = crc16_byte(crc_acc, b);
        cmd_known = cmd_is_known(b);
        pay_cnt   = '0;
        queue_result(fprc_pkg::KIND_CMD, b, 8'h00);
        rx_phase  = (pay_len == 0) ? fprc_pkg::PH_CRCHI : fprc_pkg::PH_DATA;
      end
      fprc_pkg::PH_DATA: begin
        crc_acc = crc16_byte(crc_acc, b);
        queue_result(fprc_pkg::KIND_PAYLOAD, b, pay_cnt[7:0]);
        pay_cnt = pay_cnt + 9'd1;
        if ({7'h00, pay_cnt} >= pay_len) rx_phase = fprc_pkg::PH_CRCHI;
      end
      fprc_pkg::PH_CRCHI: begin
        crc_rx   = {b, 8'h00};
        rx_phase = fprc_pkg::PH_CRCLO;
      end
      default: begin
        crc_rx = crc_rx | {8'h00, b};
        queue_result((crc_rx == crc_acc) ? fprc_pkg::KIND_GOOD : fprc_pkg::KIND_CRC_ERR,
                     8'h00, 8'h00);
        rx_phase = fprc_pkg::PH_HUNT;
      end
    endcase
    if (eoc) rx_phase = fprc_pkg::PH_HUNT;
  endfunction

  // Idle lengths: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: one byte per handshake, random gaps between requests
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tlast);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          nxt = byte_q.pop_front();
          s_tdata  <= nxt.b;
          s_tlast  <= nxt.eoc;
          s_tvalid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random backpressure, in-order compare against the model
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind  = fprc_pkg::kind_e'(m_tuser);
        got.data  = m_tdata[7:0];
        got.idx   = m_tdata[15:8];
        got.flen  = m_tdata[23:16];
        got.known = m_tdata[24];
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind=%0d byte=%02h",
                   $time, m_tuser, got.data);
          $display("%0t:   idx=%0d len=%0d known=%0b",
                   $time, got.idx, got.flen, got.known);
          mismatch_cnt++;
        end else begin
          want = result_q.pop_front();
          if (got !== want || m_tdata[31:25] !== 7'h00) begin
            $display("%0t: mismatch: expected kind=%0d byte=%02h idx=%0d len=%0d known=%0b",
                     $time, want.kind, want.data, want.idx, want.flen, want.known);
            $display("%0t: actual kind=%0d byte=%02h idx=%0d len=%0d known=%0b pad=%02h",
                     $time, m_tuser, got.data, got.idx, got.flen, got.known,
                     m_tdata[31:25]);
            mismatch_cnt++;
          end
          case (want.kind)
            fprc_pkg::KIND_CMD:     n_cmd++;
            fprc_pkg::KIND_PAYLOAD: n_pay++;
            fprc_pkg::KIND_GOOD:    n_good++;
            default:                n_bad++;
          endcase
        end
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, result_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------
  // Setup cycle, then access cycle; a write lands at the edge closing the access.
  task automatic apb_access(input logic wr, input logic [3:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    logic [31:0] dummy;
    apb_access(1'b1, {idx, 2'b00}, {24'h0, val}, dummy);
    case (idx)
      fprc_pkg::REG_SYNC_FIRST:  cfg_sync1  = val;
      fprc_pkg::REG_SYNC_SECOND: cfg_sync2  = val;
      fprc_pkg::REG_MAX_LEN:     cfg_maxlen = val;
      default: ;  // unmapped index: write is dropped
    endcase
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    logic [7:0]  shadow;
    for (int i = 0; i < 3; i++) begin
      apb_access(1'b0, 4'(i * 4), 32'h0, rd);
      shadow = (i == fprc_pkg::REG_SYNC_FIRST)  ? cfg_sync1 :
               (i == fprc_pkg::REG_SYNC_SECOND) ? cfg_sync2 : cfg_maxlen;
      if (rd !== {24'h0, shadow}) begin
        $display("%0t: register %0d readback: expected %08h, actual %08h",
                 $time, i, {24'h0, shadow}, rd);
        mismatch_cnt++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic eoc);
    rx_byte_t it;
    it.b   = b;
    it.eoc = eoc;
    byte_q.push_back(it);
    pushed_cnt++;
  endtask

  // Full frame under the current sync bytes. eoc_at marks a byte with tlast
  // (-1 for none); corrupt spoils the trailing CRC.
  task automatic push_frame(input logic [7:0] cmd, input int unsigned len,
                            input logic corrupt, input int eoc_at);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    logic [15:0] len16;
    len16 = len[15:0];
    fb.push_back(cfg_sync1);
    fb.push_back(cfg_sync2);
    fb.push_back(len16[15:8]);
    fb.push_back(len16[7:0]);
    fb.push_back(cmd);
    for (int i = 0; i < len; i++) fb.push_back(8'($urandom_range(255)));
    crc = 16'h0000;
    foreach (fb[i]) crc = crc16_byte(crc, fb[i]);
    if (corrupt) crc = crc ^ 16'($urandom_range(1, 65535));
    fb.push_back(crc[15:8]);
    fb.push_back(crc[7:0]);
    foreach (fb[i]) push_byte(fb[i], i == eoc_at);
  endtask

  function automatic logic [7:0] rand_cmd();
    if ($urandom_range(1)) return known_cmds[$urandom_range(5)];
    return 8'($urandom_range(255));
  endfunction

  // Mostly short payloads; rarely the largest the limit allows.
  function automatic int unsigned rand_len();
    if ($urandom_range(99) < 3) return cfg_maxlen;
    return $urandom_range(0, (cfg_maxlen < 12) ? cfg_maxlen : 12);
  endfunction

  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned stop_at, r, len;
    int          eoc_at;
    logic [15:0] bad_len;
    stop_at = pushed_cnt + n_bytes;
    while (pushed_cnt < stop_at) begin
      r = $urandom_range(99);
      if (r < 65) begin
        // well-formed frame, occasionally spoiled or cut by an end of chunk
        len = rand_len();
        case ($urandom_range(9))
          0:       eoc_at = $urandom_range(0, len + 5);
          1:       eoc_at = len + 6;
          default: eoc_at = -1;
        endcase
        push_frame(rand_cmd(), len, $urandom_range(4) == 0, eoc_at);
      end else if (r < 75) begin
        // header with a length the block must refuse
        if (cfg_maxlen != 8'hFF && $urandom_range(1))
          bad_len = 16'($urandom_range(cfg_maxlen + 1, 255));
        else
          bad_len = 16'($urandom_range(MaxFramePayload, 65535));
        push_byte(cfg_sync1, 1'b0);
        push_byte(cfg_sync2, 1'b0);
        push_byte(bad_len[15:8], 1'b0);
        push_byte(bad_len[7:0], 1'b0);
      end else if (r < 85) begin
        // broken second sync, sometimes a repeated first sync
        push_byte(cfg_sync1, 1'b0);
        push_byte($urandom_range(1) ? cfg_sync1 : cfg_sync2 ^ 8'($urandom_range(1, 255)),
                  1'b0);
      end else begin
        // line noise, often closed by an end of chunk
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          push_byte(8'($urandom_range(255)),
                    (i == len - 1) ? 1'($urandom_range(1)) : ($urandom_range(7) == 0));
      end
    end
  endtask

  // Block until all requests are sent and all results are back, then let the
  // output register settle before touching registers.
  task automatic wait_idle();
    @(posedge clk_i);
    while (byte_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_setting(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] ml, input logic flat_out,
                             input logic pause_mid);
    write_reg(fprc_pkg::REG_SYNC_FIRST, s1);
    write_reg(fprc_pkg::REG_SYNC_SECOND, s2);
    write_reg(fprc_pkg::REG_MAX_LEN, ml);
    check_regs();
    setting_cnt++;
    no_idle = flat_out;
    if (pause_mid) begin
      // hold off the sender until every owed result has come back
      random_traffic(40);
      wait_idle();
      random_traffic(40);
    end else begin
      random_traffic(80);
    end
    wait_idle();
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset register values.
    push_frame(fprc_pkg::CmdA, 0, 1'b0, -1);   // zero length, known command, good CRC
    push_frame(8'h00, 1, 1'b1, -1);            // unknown command, CRC error
    push_byte(fprc_pkg::SyncFirstRst, 1'b0);   // second sync wrong (repeated first
    push_byte(fprc_pkg::SyncFirstRst, 1'b0);   // sync), not retried, so the
    push_byte(fprc_pkg::SyncSecRst, 1'b0);     // next byte is just hunted over
    push_byte(fprc_pkg::SyncFirstRst, 1'b0);   // length 256: dropped
    push_byte(fprc_pkg::SyncSecRst, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(fprc_pkg::SyncFirstRst, 1'b0);   // end of chunk inside a header
    push_byte(fprc_pkg::SyncSecRst, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle();

    run_setting(fprc_pkg::SyncFirstRst, fprc_pkg::SyncSecRst, fprc_pkg::MaxLenRst,
                1'b0, 1'b0);
    run_setting(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);  // only empty payloads pass
    run_setting(8'hFF, 8'h00, 8'h01, 1'b0, 1'b0);
    run_setting(8'h5A, 8'h5A, 8'h10, 1'b0, 1'b0);  // both sync bytes equal
    run_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(40)), 1'b0, 1'b0);

    // Unmapped register index must leave the real ones alone.
    write_reg(RegUnused, 8'hA5);
    check_regs();
    run_setting(8'hC3, 8'h3C, 8'hFF, 1'b0, 1'b1);

    wait_idle();
    if (result_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, result_q.size());
      mismatch_cnt++;
    end
    $display("Sent %0d bytes over %0d register settings plus reset values.",
             pushed_cnt, setting_cnt);
    $display("Checked %0d command, %0d payload, %0d good-frame, %0d CRC-error results.",
             n_cmd, n_pay, n_good, n_bad);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
